FILE: hdl/tdcapw_pkg.sv
// Shared types and field constants for the timing/amplitude pair word decoder.
`timescale 1ns / 1ps

package tdcapw_pkg;

    // Readout word and count widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 9;

    // Fixed values that timing fields are subtracted from
    localparam logic [5:0]  CYCLE_TOP = 6'd63;
    localparam logic [11:0] TIME_TOP  = 12'd4095;

    // Parser phase; the unused code behaves as header
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_TIMING = 2'd1,
        PH_AMPL   = 2'd2
    } phase_t;

    // One buffered input word
    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic              last;
    } in_word_t;

    // One decoded pair record
    typedef struct packed {
        logic        pair_mismatch;
        logic [11:0] time_value;
        logic [5:0]  clock_cycle;
        logic [11:0] amplitude;
        logic [4:0]  channel_id;
        logic [4:0]  module_id;
        logic [3:0]  board_id;
        logic [3:0]  crate_id;
    } record_t;

    // Parser status seen by the pipeline control
    typedef struct packed {
        logic   emit;
        phase_t phase;
    } parse_stat_t;

endpackage

FILE: hdl/tdc_adc_pair_word_decoder.sv
// Top level of the timing/amplitude pair word decoder.
`timescale 1ns / 1ps

// Decodes a readout stream of 32-bit words (first buffer byte in bits 31:24):
// a header word with crate, board and a 9-bit count, then timing/amplitude
// word pairs, each pair giving one record on the master side. tlast on the
// slave side marks the end of a buffer; an unfinished pair is dropped there.
// One word is accepted every cycle unless the master side stalls. A record passes
// the input register, then the result register, to the master side. A stalled
// master side holds the pipeline once both registers are full.

module tdc_adc_pair_word_decoder
    import tdcapw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] data_word
    input  logic [31:0] s_axis_tdata,
    // end_of_buffer
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] crate_id, [7:4] board_id, [12:8] module_id, [17:13] channel_id,
    // [29:18] amplitude, [35:30] clock_cycle, [47:36] time_value
    output logic [47:0] m_axis_tdata,
    // [0] pair_mismatch
    output logic        m_axis_tuser
);

    in_word_t    in_word;
    in_word_t    held_word;
    logic        held_valid;
    logic        advance;
    logic        out_free;
    logic        out_load;
    parse_stat_t stat;
    record_t     rec;
    record_t     rec_out;

    assign in_word.data = s_axis_tdata;
    assign in_word.last = s_axis_tlast;

    // Move a word through the parser unless its record has nowhere to go
    assign advance  = held_valid && (!stat.emit || out_free);
    assign out_load = advance && stat.emit;

    tdcapw_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .advance    (advance),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    tdcapw_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .word    (held_word),
        .stat    (stat),
        .rec     (rec)
    );

    tdcapw_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .rec_in    (rec),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_free  (out_free),
        .rec_out   (rec_out)
    );

    // Pack the record onto the master side
    assign m_axis_tdata = {rec_out.time_value, rec_out.clock_cycle, rec_out.amplitude,
                           rec_out.channel_id, rec_out.module_id, rec_out.board_id,
                           rec_out.crate_id};
    assign m_axis_tuser = rec_out.pair_mismatch;

    // An empty input register always takes a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !held_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    // A record blocked by a stalled sink keeps both stages full
    a_no_record_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_valid && stat.emit && m_axis_tvalid && !m_axis_tready)
        |=> (held_valid && m_axis_tvalid))
        else $error("pending record lost under back-pressure");

    // End of buffer returns the parser to header
    a_eob_to_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && held_word.last) |=> (stat.phase == PH_HEADER))
        else $error("parser not in header phase after end of buffer");

    // A record is only produced from the amplitude phase
    a_load_in_ampl: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(stat.phase == PH_AMPL))
        else $error("record produced outside amplitude phase");

endmodule

FILE: hdl/tdcapw_in_stage.sv
// Input register stage: holds one accepted readout word until the parser takes it.
`timescale 1ns / 1ps

module tdcapw_in_stage
    import tdcapw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     advance,
    output logic     held_valid,
    output in_word_t held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    // Take a new word when empty or when the held word moves on
    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

FILE: hdl/tdcapw_parser.sv
// Header/timing/amplitude parser: holds block state and decodes one pair record.
`timescale 1ns / 1ps

module tdcapw_parser
    import tdcapw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  in_word_t    word,
    output parse_stat_t stat,
    output record_t     rec
);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  remain_reg, remain_next;
    logic [COUNT_W-1:0]  remain_dec;
    logic [3:0]          crate_reg, board_reg;
    logic [4:0]          module_reg, channel_reg;
    logic                adc_reg;
    logic [5:0]          cycle_reg;
    logic [11:0]         time_reg;
    logic                load_header;
    logic                load_timing;
    logic [4:0]          w_module, w_channel;
    logic                w_adc;
    logic                pair_ok;

    assign w_module  = word.data[31:27];
    assign w_channel = word.data[26:22];
    assign w_adc     = word.data[21];

    // Count drops by two per pair and stops at zero
    assign remain_dec = (remain_reg > COUNT_W'(2)) ? (remain_reg - COUNT_W'(2))
                                                   : '0;

    // Next phase and count
    always_comb begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        load_header = 1'b0;
        load_timing = 1'b0;
        case (phase_reg)
            PH_TIMING: begin
                load_timing = 1'b1;
                phase_next  = PH_AMPL;
            end
            PH_AMPL: begin
                remain_next = remain_dec;
                phase_next  = (remain_dec != '0) ? PH_TIMING : PH_HEADER;
            end
            default: begin
                load_header = 1'b1;
                remain_next = word.data[COUNT_W-1:0];
                phase_next  = (word.data[COUNT_W-1:0] != '0) ? PH_TIMING : PH_HEADER;
            end
        endcase
        // End of buffer drops any open pair
        if (word.last) begin
            phase_next  = PH_HEADER;
            remain_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            remain_reg <= '0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
        end
    end

    // Hold header ids and the pending timing word
    always_ff @(posedge aclk) begin
        if (advance && load_header) begin
            crate_reg <= word.data[31:28];
            board_reg <= word.data[27:24];
        end
        if (advance && load_timing) begin
            module_reg  <= w_module;
            channel_reg <= w_channel;
            adc_reg     <= w_adc;
            cycle_reg   <= CYCLE_TOP - word.data[17:12];
            time_reg    <= TIME_TOP - word.data[11:0];
        end
    end

    // Pair must match in module and channel, flags 0 then 1
    assign pair_ok = (w_module == module_reg) && (w_channel == channel_reg) &&
                     !adc_reg && w_adc;

    always_comb begin
        rec.crate_id      = crate_reg;
        rec.board_id      = board_reg;
        rec.module_id     = module_reg;
        rec.channel_id    = channel_reg;
        rec.amplitude     = word.data[11:0];
        rec.clock_cycle   = cycle_reg;
        rec.time_value    = time_reg;
        rec.pair_mismatch = !pair_ok;
    end

    assign stat.emit  = (phase_reg == PH_AMPL);
    assign stat.phase = phase_reg;

endmodule

FILE: hdl/tdcapw_out_stage.sv
// Result register stage: holds one pair record until the sink takes it.
`timescale 1ns / 1ps

module tdcapw_out_stage
    import tdcapw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  record_t rec_in,
    input  logic    out_ready,
    output logic    out_valid,
    output logic    out_free,
    output record_t rec_out
);

    logic    valid_reg;
    logic    valid_next;
    record_t rec_reg;

    // Free when empty or the current record leaves this cycle
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            rec_reg <= rec_in;
        end
    end

    assign out_valid = valid_reg;
    assign rec_out   = rec_reg;

endmodule
